// ----- src/pvfr_pkg.sv -----
// pvfr_pkg: widths, register codes, reset values and item types shared by
// the planar velocity force regulator. No dependencies.
package pvfr_pkg;

    // field and register widths
    localparam int VEL_W      = 16;
    localparam int MAG_W      = 16;
    localparam int MASS_W     = 20;
    localparam int INER_W     = 32;
    localparam int LIM_W      = 31;
    localparam int STEP_W     = 20;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // internal datapath widths
    localparam int DIV1_W = 48;   // numerators of the step-time divide
    localparam int FRC_W  = 46;   // unlimited force magnitude
    localparam int HALF_W = 23;   // half of a force magnitude for squaring
    localparam int SQ_W   = 94;   // force magnitude squared, even for the root
    localparam int ROOT_W = 47;   // floor root of the squared magnitude
    localparam int FM_W   = 77;   // force times force limit
    localparam int Q2_W   = 31;   // scaled force magnitude

    // item queue depth
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASS       = 3'd0,
        CFG_INERTIA    = 3'd1,
        CFG_MAX_FORCE  = 3'd2,
        CFG_MAX_TORQUE = 3'd3,
        CFG_STEP_TIME  = 3'd4
    } t_cfg_idx;

    // reset values
    localparam logic [MASS_W-1:0] RST_MASS       = 20'd1000;
    localparam logic [INER_W-1:0] RST_INERTIA    = 32'd1000000;
    localparam logic [LIM_W-1:0]  RST_MAX_FORCE  = 31'd100000;
    localparam logic [LIM_W-1:0]  RST_MAX_TORQUE = 31'd10000;
    localparam logic [STEP_W-1:0] RST_STEP_TIME  = 20'd5000;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic [INER_W-1:0] inertia;
        logic [LIM_W-1:0]  max_force;
        logic [LIM_W-1:0]  max_torque;
        logic [STEP_W-1:0] step;       // never zero
    } t_cfg;

    typedef struct packed {
        logic nx;
        logic ny;
        logic nz;
    } t_sign;

    // classified item: error magnitudes and signs
    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [MAG_W-1:0] az;
        t_sign            sg;
    } t_item;

    // carried alongside the square root
    typedef struct packed {
        logic [FM_W-1:0] fxm;
        logic [FM_W-1:0] fym;
        logic [Q2_W-1:0] fx;
        logic [Q2_W-1:0] fy;
        logic [Q2_W-1:0] tz;
        logic            flim;
        logic            tlim;
        t_sign           sg;
    } t_root_tag;

    // carried alongside the scaling divide
    typedef struct packed {
        logic [Q2_W-1:0] fx;
        logic [Q2_W-1:0] fy;
        logic [Q2_W-1:0] tz;
        logic            flim;
        logic            tlim;
        t_sign           sg;
    } t_quo_tag;

endpackage

// ----- src/pvfr_div.sv -----
// pvfr_div: pipelined restoring divider, one quotient bit per stage,
// several lanes sharing one divisor, with a sideband tag. Uses no package.
module pvfr_div #(
    parameter int LANES = 2,
    parameter int NW    = 48,
    parameter int DW    = 20,
    parameter int QW    = 48,
    parameter int TW    = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NW-1:0]     i_num,
    input  logic [DW-1:0]                i_den,
    input  logic [TW-1:0]                i_tag,
    output logic                         o_valid,
    output logic [LANES-1:0][QW-1:0]     o_quo,
    output logic [TW-1:0]                o_tag
);

    logic                     r_vld [QW];
    logic [LANES-1:0][DW-1:0] r_rem [QW];
    logic [LANES-1:0][NW-1:0] r_num [QW];
    logic [LANES-1:0][QW-1:0] r_quo [QW];
    logic [DW-1:0]            r_den [QW];
    logic [TW-1:0]            r_tag [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic                     s_vld;
        logic [LANES-1:0][DW-1:0] s_rem;
        logic [LANES-1:0][NW-1:0] s_num;
        logic [LANES-1:0][QW-1:0] s_quo;
        logic [DW-1:0]            s_den;
        logic [TW-1:0]            s_tag;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;

        // stage inputs: the item itself or the previous stage
        if (k == 0) begin : g_first
            always_comb begin
                s_vld = i_valid;
                s_num = i_num;
                s_den = i_den;
                s_tag = i_tag;
                s_quo = '0;
                for (int l = 0; l < LANES; l++) begin
                    s_rem[l] = DW'(i_num[l] >> QW);
                end
            end
        end else begin : g_next
            always_comb begin
                s_vld = r_vld[k-1];
                s_num = r_num[k-1];
                s_den = r_den[k-1];
                s_tag = r_tag[k-1];
                s_quo = r_quo[k-1];
                s_rem = r_rem[k-1];
            end
        end

        // one restoring step per lane
        always_comb begin
            logic [DW:0] t;
            n_rem = s_rem;
            n_quo = s_quo;
            for (int l = 0; l < LANES; l++) begin
                t = {s_rem[l], s_num[l][BIT]};
                if (t >= {1'b0, s_den}) begin
                    n_rem[l]      = DW'(t - {1'b0, s_den});
                    n_quo[l][BIT] = 1'b1;
                end else begin
                    n_rem[l] = DW'(t);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_quo[k] <= n_quo;
            r_num[k] <= s_num;
            r_den[k] <= s_den;
            r_tag[k] <= s_tag;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

// ----- src/pvfr_sqrt.sv -----
// pvfr_sqrt: pipelined digit-by-digit floor square root, one root bit per
// stage, with a sideband tag. Uses no package.
module pvfr_sqrt #(
    parameter int NW = 94,
    parameter int TW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [NW-1:0]      i_num,
    input  logic [TW-1:0]      i_tag,
    output logic               o_valid,
    output logic [NW/2-1:0]    o_root,
    output logic [TW-1:0]      o_tag
);

    localparam int RTW = NW / 2;

    logic             r_vld  [RTW];
    logic [RTW+1:0]   r_rem  [RTW];
    logic [RTW-1:0]   r_root [RTW];
    logic [NW-1:0]    r_num  [RTW];
    logic [TW-1:0]    r_tag  [RTW];

    for (genvar k = 0; k < RTW; k++) begin : g_stage
        localparam int TOP = NW - 1 - 2 * k;

        logic           s_vld;
        logic [RTW+1:0] s_rem;
        logic [RTW-1:0] s_root;
        logic [NW-1:0]  s_num;
        logic [TW-1:0]  s_tag;
        logic [RTW+1:0] n_rem;
        logic [RTW-1:0] n_root;

        if (k == 0) begin : g_first
            always_comb begin
                s_vld  = i_valid;
                s_rem  = '0;
                s_root = '0;
                s_num  = i_num;
                s_tag  = i_tag;
            end
        end else begin : g_next
            always_comb begin
                s_vld  = r_vld[k-1];
                s_rem  = r_rem[k-1];
                s_root = r_root[k-1];
                s_num  = r_num[k-1];
                s_tag  = r_tag[k-1];
            end
        end

        // bring down two bits, try root*4+1
        always_comb begin
            logic [RTW+3:0] t;
            logic [RTW+3:0] trial;
            t     = {s_rem, s_num[TOP -: 2]};
            trial = (RTW+4)'({s_root, 2'b01});
            if (t >= trial) begin
                n_rem  = (RTW+2)'(t - trial);
                n_root = {s_root[RTW-2:0], 1'b1};
            end else begin
                n_rem  = (RTW+2)'(t);
                n_root = {s_root[RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_num[k]  <= s_num;
            r_tag[k]  <= s_tag;
        end
    end

    assign o_valid = r_vld[RTW-1];
    assign o_root  = r_root[RTW-1];
    assign o_tag   = r_tag[RTW-1];

endmodule

// ----- src/pvfr_front.sv -----
// pvfr_front: accepts items and classifies each velocity error into sign and
// magnitude for the queue. Depends on pvfr_pkg.
module pvfr_front (
    input  logic                          i_start,
    input  logic                          i_full,
    input  logic signed [pvfr_pkg::VEL_W-1:0] i_target_vx,
    input  logic signed [pvfr_pkg::VEL_W-1:0] i_target_vy,
    input  logic signed [pvfr_pkg::VEL_W-1:0] i_target_yaw_rate,
    input  logic signed [pvfr_pkg::VEL_W-1:0] i_meas_vx,
    input  logic signed [pvfr_pkg::VEL_W-1:0] i_meas_vy,
    input  logic signed [pvfr_pkg::VEL_W-1:0] i_meas_yaw_rate,
    output logic                          o_busy,
    output logic                          o_push,
    output pvfr_pkg::t_item               o_item
);
    import pvfr_pkg::*;

    logic signed [VEL_W:0] ex;
    logic signed [VEL_W:0] ey;
    logic signed [VEL_W:0] ez;

    // item accepted whenever the queue has room
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    // velocity errors at one extra bit
    assign ex = (VEL_W+1)'(i_target_vx) - (VEL_W+1)'(i_meas_vx);
    assign ey = (VEL_W+1)'(i_target_vy) - (VEL_W+1)'(i_meas_vy);
    assign ez = (VEL_W+1)'(i_target_yaw_rate) - (VEL_W+1)'(i_meas_yaw_rate);

    // sign and magnitude
    always_comb begin
        o_item.sg.nx = ex[VEL_W];
        o_item.sg.ny = ey[VEL_W];
        o_item.sg.nz = ez[VEL_W];
        o_item.ax    = ex[VEL_W] ? MAG_W'(-ex) : MAG_W'(ex);
        o_item.ay    = ey[VEL_W] ? MAG_W'(-ey) : MAG_W'(ey);
        o_item.az    = ez[VEL_W] ? MAG_W'(-ez) : MAG_W'(ez);
    end

endmodule

// ----- src/pvfr_queue.sv -----
// pvfr_queue: small item queue between the front and the back end.
// Depends on pvfr_pkg.
module pvfr_queue #(
    parameter int DEPTH = pvfr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pvfr_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output pvfr_pkg::t_item o_item
);
    import pvfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (!i_push && do_pop) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

// ----- src/pvfr_back.sv -----
// pvfr_back: force and torque datapath: step-time divide, magnitude test,
// square root, scaling divide and output register. Depends on pvfr_pkg,
// pvfr_div and pvfr_sqrt.
module pvfr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  pvfr_pkg::t_item               i_item,
    input  pvfr_pkg::t_cfg                i_cfg,
    output logic                          o_done,
    output logic signed [pvfr_pkg::OUT_W-1:0] o_force_x,
    output logic signed [pvfr_pkg::OUT_W-1:0] o_force_y,
    output logic signed [pvfr_pkg::OUT_W-1:0] o_torque_z,
    output logic                          o_force_limited,
    output logic                          o_torque_limited
);
    import pvfr_pkg::*;

    localparam int P1_W = MAG_W + MASS_W;
    localparam int PT_W = MAG_W + INER_W;
    localparam int PH_W = 2 * HALF_W;
    localparam int PM_W = HALF_W + LIM_W;
    localparam int SS_W = 2 * FRC_W;
    localparam int MF_W = 2 * LIM_W;

    // stage 1: error times mass and inertia
    logic             r1_vld;
    logic [P1_W-1:0]  r1_px;
    logic [P1_W-1:0]  r1_py;
    logic [PT_W-1:0]  r1_pt;
    t_sign            r1_sg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px <= P1_W'(i_item.ax) * P1_W'(i_cfg.mass);
        r1_py <= P1_W'(i_item.ay) * P1_W'(i_cfg.mass);
        r1_pt <= PT_W'(i_item.az) * PT_W'(i_cfg.inertia);
        r1_sg <= i_item.sg;
    end

    // stage 2: grams to millinewtons
    logic              r2_vld;
    logic [DIV1_W-1:0] r2_nx;
    logic [DIV1_W-1:0] r2_ny;
    logic [DIV1_W-1:0] r2_nt;
    t_sign             r2_sg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_nx <= DIV1_W'(r1_px) * DIV1_W'(10'd1000);
        r2_ny <= DIV1_W'(r1_py) * DIV1_W'(10'd1000);
        r2_nt <= DIV1_W'(r1_pt);
        r2_sg <= r1_sg;
    end

    // divide by step time
    logic [2:0][DIV1_W-1:0] d1_num;
    logic [2:0][DIV1_W-1:0] d1_quo;
    logic                   d1_vld;
    t_sign                  d1_sg;

    assign d1_num[0] = r2_nx;
    assign d1_num[1] = r2_ny;
    assign d1_num[2] = r2_nt;

    pvfr_div #(
        .LANES (3),
        .NW    (DIV1_W),
        .DW    (STEP_W),
        .QW    (DIV1_W),
        .TW    ($bits(t_sign))
    ) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   (d1_num),
        .i_den   (i_cfg.step),
        .i_tag   (r2_sg),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_tag   (d1_sg)
    );

    // stage 3: partial squares, partial scaling products, torque clamp
    logic [FRC_W-1:0]  fx3;
    logic [FRC_W-1:0]  fy3;
    logic              tlim3;
    logic              r3_vld;
    logic [PH_W-1:0]   r3_xhh, r3_xhl, r3_xll;
    logic [PH_W-1:0]   r3_yhh, r3_yhl, r3_yll;
    logic [PM_W-1:0]   r3_xmh, r3_xml, r3_ymh, r3_yml;
    logic [Q2_W-1:0]   r3_fx, r3_fy, r3_tz;
    logic              r3_tlim;
    t_sign             r3_sg;

    assign fx3   = d1_quo[0][FRC_W-1:0];
    assign fy3   = d1_quo[1][FRC_W-1:0];
    assign tlim3 = d1_quo[2] > DIV1_W'(i_cfg.max_torque);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_xhh  <= PH_W'(fx3[FRC_W-1:HALF_W]) * PH_W'(fx3[FRC_W-1:HALF_W]);
        r3_xhl  <= PH_W'(fx3[FRC_W-1:HALF_W]) * PH_W'(fx3[HALF_W-1:0]);
        r3_xll  <= PH_W'(fx3[HALF_W-1:0]) * PH_W'(fx3[HALF_W-1:0]);
        r3_yhh  <= PH_W'(fy3[FRC_W-1:HALF_W]) * PH_W'(fy3[FRC_W-1:HALF_W]);
        r3_yhl  <= PH_W'(fy3[FRC_W-1:HALF_W]) * PH_W'(fy3[HALF_W-1:0]);
        r3_yll  <= PH_W'(fy3[HALF_W-1:0]) * PH_W'(fy3[HALF_W-1:0]);
        r3_xmh  <= PM_W'(fx3[FRC_W-1:HALF_W]) * PM_W'(i_cfg.max_force);
        r3_xml  <= PM_W'(fx3[HALF_W-1:0]) * PM_W'(i_cfg.max_force);
        r3_ymh  <= PM_W'(fy3[FRC_W-1:HALF_W]) * PM_W'(i_cfg.max_force);
        r3_yml  <= PM_W'(fy3[HALF_W-1:0]) * PM_W'(i_cfg.max_force);
        r3_fx   <= fx3[Q2_W-1:0];
        r3_fy   <= fy3[Q2_W-1:0];
        r3_tz   <= tlim3 ? i_cfg.max_torque : d1_quo[2][Q2_W-1:0];
        r3_tlim <= tlim3;
        r3_sg   <= d1_sg;
    end

    // stage 4: assemble squares and scaling products, square the limit
    logic              r4_vld;
    logic [SS_W-1:0]   r4_sqx, r4_sqy;
    logic [FM_W-1:0]   r4_fxm, r4_fym;
    logic [MF_W-1:0]   r4_mf2;
    logic [Q2_W-1:0]   r4_fx, r4_fy, r4_tz;
    logic              r4_tlim;
    t_sign             r4_sg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_sqx  <= (SS_W'(r3_xhh) << (2 * HALF_W)) + (SS_W'(r3_xhl) << (HALF_W + 1))
                 + SS_W'(r3_xll);
        r4_sqy  <= (SS_W'(r3_yhh) << (2 * HALF_W)) + (SS_W'(r3_yhl) << (HALF_W + 1))
                 + SS_W'(r3_yll);
        r4_fxm  <= (FM_W'(r3_xmh) << HALF_W) + FM_W'(r3_xml);
        r4_fym  <= (FM_W'(r3_ymh) << HALF_W) + FM_W'(r3_yml);
        r4_mf2  <= MF_W'(i_cfg.max_force) * MF_W'(i_cfg.max_force);
        r4_fx   <= r3_fx;
        r4_fy   <= r3_fy;
        r4_tz   <= r3_tz;
        r4_tlim <= r3_tlim;
        r4_sg   <= r3_sg;
    end

    // stage 5: squared magnitude
    logic              r5_vld;
    logic [SQ_W-1:0]   r5_sq;
    logic [MF_W-1:0]   r5_mf2;
    logic [FM_W-1:0]   r5_fxm, r5_fym;
    logic [Q2_W-1:0]   r5_fx, r5_fy, r5_tz;
    logic              r5_tlim;
    t_sign             r5_sg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_sq   <= SQ_W'(r4_sqx) + SQ_W'(r4_sqy);
        r5_mf2  <= r4_mf2;
        r5_fxm  <= r4_fxm;
        r5_fym  <= r4_fym;
        r5_fx   <= r4_fx;
        r5_fy   <= r4_fy;
        r5_tz   <= r4_tz;
        r5_tlim <= r4_tlim;
        r5_sg   <= r4_sg;
    end

    // stage 6: magnitude limit test
    logic              r6_vld;
    logic [SQ_W-1:0]   r6_sq;
    t_root_tag         r6_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_sq       <= r5_sq;
        r6_tag.fxm  <= r5_fxm;
        r6_tag.fym  <= r5_fym;
        r6_tag.fx   <= r5_fx;
        r6_tag.fy   <= r5_fy;
        r6_tag.tz   <= r5_tz;
        r6_tag.flim <= r5_sq > SQ_W'(r5_mf2);
        r6_tag.tlim <= r5_tlim;
        r6_tag.sg   <= r5_sg;
    end

    // floor root of the squared magnitude
    logic              rt_vld;
    logic [ROOT_W-1:0] rt_root;
    t_root_tag         rt_tag;

    pvfr_sqrt #(
        .NW (SQ_W),
        .TW ($bits(t_root_tag))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_num   (r6_sq),
        .i_tag   (r6_tag),
        .o_valid (rt_vld),
        .o_root  (rt_root),
        .o_tag   (rt_tag)
    );

    // scale by limit over magnitude
    logic [1:0][FM_W-1:0] d2_num;
    logic [1:0][Q2_W-1:0] d2_quo;
    logic                 d2_vld;
    t_quo_tag             d2_in_tag;
    t_quo_tag             d2_tag;

    assign d2_num[0]      = rt_tag.fxm;
    assign d2_num[1]      = rt_tag.fym;
    assign d2_in_tag.fx   = rt_tag.fx;
    assign d2_in_tag.fy   = rt_tag.fy;
    assign d2_in_tag.tz   = rt_tag.tz;
    assign d2_in_tag.flim = rt_tag.flim;
    assign d2_in_tag.tlim = rt_tag.tlim;
    assign d2_in_tag.sg   = rt_tag.sg;

    pvfr_div #(
        .LANES (2),
        .NW    (FM_W),
        .DW    (ROOT_W),
        .QW    (Q2_W),
        .TW    ($bits(t_quo_tag))
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rt_vld),
        .i_num   (d2_num),
        .i_den   (rt_root),
        .i_tag   (d2_in_tag),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_tag   (d2_tag)
    );

    // output register: pick scaled or plain force, restore signs
    logic [Q2_W-1:0] mx;
    logic [Q2_W-1:0] my;

    assign mx = d2_tag.flim ? d2_quo[0] : d2_tag.fx;
    assign my = d2_tag.flim ? d2_quo[1] : d2_tag.fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_force_x        <= d2_tag.sg.nx ? -OUT_W'(mx) : OUT_W'(mx);
        o_force_y        <= d2_tag.sg.ny ? -OUT_W'(my) : OUT_W'(my);
        o_torque_z       <= d2_tag.sg.nz ? -OUT_W'(d2_tag.tz) : OUT_W'(d2_tag.tz);
        o_force_limited  <= d2_tag.flim;
        o_torque_limited <= d2_tag.tlim;
    end

endmodule

// ----- src/planar_velocity_force_regulator.sv -----
// planar_velocity_force_regulator: top level with configuration registers,
// front end, item queue and back-end datapath. Depends on pvfr_pkg and all pvfr_ modules.
// o_done marks an item after the queue, stages 1-2, the 48-stage step-time divider,
// stages 3-6, the 47-stage square root, the 31-stage scaler and the output register.
// Throughput: one item per cycle while busy is low; busy stays low while results are streaming out.
// Reset: synchronous, active low; registers return to their defaults, pipeline empties.
module planar_velocity_force_regulator #(
    parameter int QDEPTH = pvfr_pkg::QUEUE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [pvfr_pkg::VEL_W-1:0]     i_target_vx,
    input  logic signed [pvfr_pkg::VEL_W-1:0]     i_target_vy,
    input  logic signed [pvfr_pkg::VEL_W-1:0]     i_target_yaw_rate,
    input  logic signed [pvfr_pkg::VEL_W-1:0]     i_meas_vx,
    input  logic signed [pvfr_pkg::VEL_W-1:0]     i_meas_vy,
    input  logic signed [pvfr_pkg::VEL_W-1:0]     i_meas_yaw_rate,
    output logic                                  o_done,
    output logic signed [pvfr_pkg::OUT_W-1:0]     o_force_x,
    output logic signed [pvfr_pkg::OUT_W-1:0]     o_force_y,
    output logic signed [pvfr_pkg::OUT_W-1:0]     o_torque_z,
    output logic                                  o_force_limited,
    output logic                                  o_torque_limited,
    input  logic                                  i_cfg_we,
    input  logic [pvfr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pvfr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import pvfr_pkg::*;

    logic [MASS_W-1:0] r_mass;
    logic [INER_W-1:0] r_inertia;
    logic [LIM_W-1:0]  r_max_force;
    logic [LIM_W-1:0]  r_max_torque;
    logic [STEP_W-1:0] r_step;
    t_cfg              cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass       <= RST_MASS;
            r_inertia    <= RST_INERTIA;
            r_max_force  <= RST_MAX_FORCE;
            r_max_torque <= RST_MAX_TORQUE;
            r_step       <= RST_STEP_TIME;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MASS:       r_mass       <= i_cfg_data[MASS_W-1:0];
                CFG_INERTIA:    r_inertia    <= i_cfg_data[INER_W-1:0];
                CFG_MAX_FORCE:  r_max_force  <= i_cfg_data[LIM_W-1:0];
                CFG_MAX_TORQUE: r_max_torque <= i_cfg_data[LIM_W-1:0];
                CFG_STEP_TIME:  r_step       <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // zero step time acts as one
    always_comb begin
        cfg.mass       = r_mass;
        cfg.inertia    = r_inertia;
        cfg.max_force  = r_max_force;
        cfg.max_torque = r_max_torque;
        cfg.step       = (r_step == '0) ? STEP_W'(1) : r_step;
    end

    logic  q_full;
    logic  q_valid;
    logic  push;
    t_item f_item;
    t_item q_item;

    pvfr_front u_front (
        .i_start           (start),
        .i_full            (q_full),
        .i_target_vx       (i_target_vx),
        .i_target_vy       (i_target_vy),
        .i_target_yaw_rate (i_target_yaw_rate),
        .i_meas_vx         (i_meas_vx),
        .i_meas_vy         (i_meas_vy),
        .i_meas_yaw_rate   (i_meas_yaw_rate),
        .o_busy            (busy),
        .o_push            (push),
        .o_item            (f_item)
    );

    pvfr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (q_valid),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pvfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_item           (q_item),
        .i_cfg            (cfg),
        .o_done           (o_done),
        .o_force_x        (o_force_x),
        .o_force_y        (o_force_y),
        .o_torque_z       (o_torque_z),
        .o_force_limited  (o_force_limited),
        .o_torque_limited (o_torque_limited)
    );

endmodule
